### rtl/core/mkd_pkg.sv
// package for the morse key decoder: widths, register defaults, codes and types
// used by every module under rtl/core except mkd_ram, no dependencies

package mkd_pkg;

    localparam int MAX_MARKS   = 6;
    localparam int MARK_CNT_W  = 3;
    localparam int TBL_DEPTH   = 126;
    localparam int TBL_ADDR_W  = 7;
    localparam int IDX_W       = (MAX_MARKS + 1 > TBL_ADDR_W) ? MAX_MARKS + 1 : TBL_ADDR_W;
    localparam int SYM_W       = 8;
    localparam int TIME_W      = 32;
    localparam int CFG_W       = 16;
    localparam int CFG_IDX_W   = 3;
    localparam int RES_DEPTH   = 8;
    localparam int RES_PTR_W   = 3;
    localparam int RES_CNT_W   = 4;

    localparam logic [CFG_W-1:0] DEF_DEBOUNCE  = 16'd50;
    localparam logic [CFG_W-1:0] DEF_DOT_LIM   = 16'd265;
    localparam logic [CFG_W-1:0] DEF_DASH_LIM  = 16'd587;
    localparam logic [CFG_W-1:0] DEF_LETTER    = 16'd595;
    localparam logic [CFG_W-1:0] DEF_WORD      = 16'd1555;
    localparam logic [CFG_W-1:0] DEF_MESSAGE   = 16'd3965;

    localparam logic [SYM_W-1:0] SPACE_CHAR = 8'h20;

    typedef enum logic {
        OP_KEY   = 1'b0,
        OP_TABLE = 1'b1
    } t_opcode;

    typedef enum logic [1:0] {
        EV_NONE   = 2'd0,
        EV_CHAR   = 2'd1,
        EV_SPACE  = 2'd2,
        EV_COMMIT = 2'd3
    } t_ev_kind;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_DEBOUNCE = 3'd0,
        CFG_DOT_LIM  = 3'd1,
        CFG_DASH_LIM = 3'd2,
        CFG_LETTER   = 3'd3,
        CFG_WORD     = 3'd4,
        CFG_MESSAGE  = 3'd5
    } t_cfg_idx;

    typedef struct packed {
        logic                  opcode;
        logic                  key_closed;
        logic [TIME_W-1:0]     now_ms;
        logic [TBL_ADDR_W-1:0] table_index;
        logic [SYM_W-1:0]      table_symbol;
    } t_in_item;

    typedef struct packed {
        logic             led_on;
        logic [1:0]       event_kind;
        logic [SYM_W-1:0] symbol;
        logic             lookup_failed;
        logic             last_result;
    } t_out_item;

    typedef struct packed {
        logic [CFG_W-1:0] debounce_ms;
        logic [CFG_W-1:0] dot_limit_ms;
        logic [CFG_W-1:0] dash_limit_ms;
        logic [CFG_W-1:0] letter_gap_ms;
        logic [CFG_W-1:0] word_gap_ms;
        logic [CFG_W-1:0] message_gap_ms;
    } t_cfg;

    typedef struct packed {
        logic valid;
        logic led;
        logic chr;
        logic hit;
        logic chk_open;
        logic ge_word;
        logic ge_msg;
    } t_s1;

    typedef struct packed {
        logic                  we;
        logic [TBL_ADDR_W-1:0] waddr;
        logic [SYM_W-1:0]      wdata;
        logic [TBL_ADDR_W-1:0] raddr;
    } t_ram_req;

    typedef struct packed {
        logic [1:0] n;
        t_out_item  r0;
        t_out_item  r1;
    } t_push;

endpackage

### rtl/core/mkd_ram.sv
// generic single write port ram with registered read
// no dependencies

module mkd_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 128,
    parameter int ADDR_W = 7
) (
    input  logic              i_clk,
    input  logic              i_we,
    input  logic [ADDR_W-1:0] i_waddr,
    input  logic [WIDTH-1:0]  i_wdata,
    input  logic [ADDR_W-1:0] i_raddr,
    output logic [WIDTH-1:0]  o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

### rtl/core/mkd_key_timer.sv
// first stage: debounce, press timing, mark gathering and table address
// depends on mkd_pkg

module mkd_key_timer (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_accept,
    input  mkd_pkg::t_in_item i_item,
    input  mkd_pkg::t_cfg    i_cfg,
    output mkd_pkg::t_s1     o_s1,
    output mkd_pkg::t_ram_req o_ram_req
);

    localparam int TW = mkd_pkg::TIME_W;
    localparam int MM = mkd_pkg::MAX_MARKS;
    localparam int CW = mkd_pkg::MARK_CNT_W;
    localparam int IW = mkd_pkg::IDX_W;
    localparam int AW = mkd_pkg::TBL_ADDR_W;

    logic [TW-1:0]  r_db_stamp, n_db_stamp;
    logic [TW-1:0]  r_chg_stamp, n_chg_stamp;
    logic           r_raw_last, n_raw_last;
    logic           r_pressed, n_pressed;
    logic [MM-1:0]  r_bits, n_bits;
    logic [CW-1:0]  r_cnt, n_cnt;
    logic [mkd_pkg::TBL_DEPTH-1:0] r_tbl_vld;
    mkd_pkg::t_s1   r_s1, n_s1;

    logic          is_key, is_tbl, raw_chg, stable;
    logic          release_ev, press_ev, chk_open;
    logic          is_dot, is_dash, push_ok, fin_full, fin_gap, idx_ok;
    logic [TW-1:0] db_diff, held, elapsed;
    logic [MM-1:0] p_bits;
    logic [CW-1:0] p_cnt;
    logic [IW-1:0] idx;

    always_comb begin
        is_key     = i_accept && (i_item.opcode == mkd_pkg::OP_KEY);
        is_tbl     = i_accept && (i_item.opcode == mkd_pkg::OP_TABLE);
        raw_chg    = i_item.key_closed != r_raw_last;
        db_diff    = i_item.now_ms - r_db_stamp;
        stable     = is_key && !raw_chg && (db_diff > TW'(i_cfg.debounce_ms));
        release_ev = stable && !i_item.key_closed && r_pressed;
        press_ev   = stable && i_item.key_closed && !r_pressed;
        chk_open   = stable && !i_item.key_closed;

        held    = i_item.now_ms - r_chg_stamp;
        is_dot  = held < TW'(i_cfg.dot_limit_ms);
        is_dash = !is_dot && (held < TW'(i_cfg.dash_limit_ms));
        push_ok = release_ev && (is_dot || is_dash) && (r_cnt < CW'(MM));

        p_bits   = push_ok ? ((r_bits << 1) | MM'(is_dash)) : r_bits;
        p_cnt    = push_ok ? (r_cnt + CW'(1)) : r_cnt;
        fin_full = push_ok && (p_cnt >= CW'(MM));

        // a release restarts the open time
        elapsed  = release_ev ? '0 : held;
        fin_gap  = chk_open && !fin_full && (p_cnt != '0)
                   && (elapsed >= TW'(i_cfg.letter_gap_ms));

        idx    = IW'(p_bits) + (IW'(1) << p_cnt) - IW'(2);
        idx_ok = idx < IW'(mkd_pkg::TBL_DEPTH);

        n_raw_last  = is_key ? i_item.key_closed : r_raw_last;
        n_db_stamp  = (is_key && raw_chg) ? i_item.now_ms : r_db_stamp;
        n_chg_stamp = (release_ev || press_ev) ? i_item.now_ms : r_chg_stamp;
        n_pressed   = press_ev ? 1'b1 : (release_ev ? 1'b0 : r_pressed);
        if (!is_key) begin
            n_bits = r_bits;
            n_cnt  = r_cnt;
        end else if (fin_full || fin_gap) begin
            n_bits = '0;
            n_cnt  = '0;
        end else begin
            n_bits = p_bits;
            n_cnt  = p_cnt;
        end

        n_s1.valid    = is_key;
        n_s1.led      = n_pressed;
        n_s1.chr      = fin_full || fin_gap;
        n_s1.hit      = idx_ok && r_tbl_vld[idx[AW-1:0]];
        n_s1.chk_open = chk_open;
        n_s1.ge_word  = elapsed >= TW'(i_cfg.word_gap_ms);
        n_s1.ge_msg   = elapsed >= TW'(i_cfg.message_gap_ms);

        o_ram_req.we    = is_tbl && (i_item.table_index < AW'(mkd_pkg::TBL_DEPTH));
        o_ram_req.waddr = i_item.table_index;
        o_ram_req.wdata = i_item.table_symbol;
        o_ram_req.raddr = idx[AW-1:0];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_db_stamp  <= '0;
            r_chg_stamp <= '0;
            r_raw_last  <= 1'b0;
            r_pressed   <= 1'b0;
            r_bits      <= '0;
            r_cnt       <= '0;
            r_tbl_vld   <= '0;
            r_s1.valid  <= 1'b0;
        end else begin
            r_db_stamp  <= n_db_stamp;
            r_chg_stamp <= n_chg_stamp;
            r_raw_last  <= n_raw_last;
            r_pressed   <= n_pressed;
            r_bits      <= n_bits;
            r_cnt       <= n_cnt;
            r_s1        <= n_s1;
            if (o_ram_req.we) begin
                r_tbl_vld[i_item.table_index] <= 1'b1;
            end
        end
    end

    assign o_s1 = r_s1;

endmodule

### rtl/core/mkd_event_gen.sv
// second stage: symbol decode, word space and commit decisions, result build
// depends on mkd_pkg

module mkd_event_gen (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  mkd_pkg::t_s1                i_s1,
    input  logic [mkd_pkg::SYM_W-1:0]   i_rdata,
    output mkd_pkg::t_push              o_push
);

    logic r_mne, n_mne;
    logic r_lws, n_lws;

    logic [mkd_pkg::SYM_W-1:0] sym;
    logic                      fail, lws_c, mne_c, do_commit, do_space, has_gap;
    mkd_pkg::t_out_item        chr_res, gap_res, none_res;

    always_comb begin
        sym       = i_s1.hit ? i_rdata : '0;
        fail      = sym == '0;
        lws_c     = i_s1.chr ? (sym == mkd_pkg::SPACE_CHAR) : r_lws;
        mne_c     = i_s1.chr ? 1'b1 : r_mne;
        do_commit = i_s1.chk_open && mne_c && i_s1.ge_msg;
        do_space  = i_s1.chk_open && mne_c && !i_s1.ge_msg && !lws_c && i_s1.ge_word;
        has_gap   = do_commit || do_space;

        chr_res.led_on        = i_s1.led;
        chr_res.event_kind    = mkd_pkg::EV_CHAR;
        chr_res.symbol        = sym;
        chr_res.lookup_failed = fail;
        chr_res.last_result   = !has_gap;

        gap_res.led_on        = i_s1.led;
        gap_res.event_kind    = do_commit ? mkd_pkg::EV_COMMIT : mkd_pkg::EV_SPACE;
        gap_res.symbol        = '0;
        gap_res.lookup_failed = 1'b0;
        gap_res.last_result   = 1'b1;

        none_res.led_on        = i_s1.led;
        none_res.event_kind    = mkd_pkg::EV_NONE;
        none_res.symbol        = '0;
        none_res.lookup_failed = 1'b0;
        none_res.last_result   = 1'b1;

        o_push.r0 = i_s1.chr ? chr_res : (has_gap ? gap_res : none_res);
        o_push.r1 = gap_res;
        if (!i_s1.valid) begin
            o_push.n = 2'd0;
        end else if (i_s1.chr && has_gap) begin
            o_push.n = 2'd2;
        end else begin
            o_push.n = 2'd1;
        end

        n_mne = r_mne;
        n_lws = r_lws;
        if (i_s1.valid) begin
            n_mne = do_commit ? 1'b0 : mne_c;
            n_lws = do_commit ? 1'b0 : (do_space ? 1'b1 : lws_c);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mne <= 1'b0;
            r_lws <= 1'b0;
        end else begin
            r_mne <= n_mne;
            r_lws <= n_lws;
        end
    end

endmodule

### rtl/core/mkd_result_fifo.sv
// result queue: takes up to two results per cycle, hands out one per transfer
// depends on mkd_pkg

module mkd_result_fifo (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  mkd_pkg::t_push                i_push,
    input  logic                          i_pop,
    output mkd_pkg::t_out_item            o_head,
    output logic [mkd_pkg::RES_CNT_W-1:0] o_count
);

    localparam int PW = mkd_pkg::RES_PTR_W;
    localparam int CW = mkd_pkg::RES_CNT_W;

    mkd_pkg::t_out_item r_mem [mkd_pkg::RES_DEPTH];
    logic [PW-1:0] r_wr, n_wr;
    logic [PW-1:0] r_rd, n_rd;
    logic [CW-1:0] r_cnt, n_cnt;

    always_comb begin
        n_wr  = r_wr + PW'(i_push.n);
        n_rd  = r_rd + PW'(i_pop);
        n_cnt = r_cnt + CW'(i_push.n) - CW'(i_pop);
    end

    always_ff @(posedge i_clk) begin
        if (i_push.n != 2'd0) begin
            r_mem[r_wr] <= i_push.r0;
        end
        if (i_push.n == 2'd2) begin
            r_mem[r_wr + PW'(1)] <= i_push.r1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            r_wr  <= n_wr;
            r_rd  <= n_rd;
            r_cnt <= n_cnt;
        end
    end

    assign o_head  = r_mem[r_rd];
    assign o_count = r_cnt;

endmodule

### rtl/core/morse_key_decoder_unit.sv
// morse key decoder top level: config registers, symbol table ram, two stages, result queue
// depends on mkd_pkg, mkd_ram, mkd_key_timer, mkd_event_gen, mkd_result_fifo
// a key sample passes the stage one register; its results are offered from the result queue
// throughput: one item per cycle while o_stall is low; results leave one per cycle while
// i_stall is low, via an 8-entry queue; two-result samples can fill it, raising o_stall
// reset: synchronous, clears all key state, queue and the 126 table valid flags at once

module morse_key_decoder_unit (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_valid,
    output logic                          o_stall,
    input  mkd_pkg::t_in_item             i_item,
    output logic                          o_valid,
    input  logic                          i_stall,
    output mkd_pkg::t_out_item            o_result,
    input  logic                          i_cfg_we,
    input  logic [mkd_pkg::CFG_IDX_W-1:0] i_cfg_index,
    input  logic [mkd_pkg::CFG_W-1:0]     i_cfg_data
);

    localparam int CW = mkd_pkg::RES_CNT_W;

    mkd_pkg::t_cfg     r_cfg;
    mkd_pkg::t_s1      s1;
    mkd_pkg::t_ram_req ram_req;
    mkd_pkg::t_push    push;
    logic [mkd_pkg::SYM_W-1:0] rdata;
    logic [CW-1:0]     q_count;
    logic              accept, pop;

    // room for every result still in flight plus two more
    assign o_stall = (q_count + (s1.valid ? CW'(2) : CW'(0))) > CW'(mkd_pkg::RES_DEPTH - 2);
    assign accept  = i_valid && !o_stall;
    assign o_valid = q_count != '0;
    assign pop     = o_valid && !i_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.debounce_ms    <= mkd_pkg::DEF_DEBOUNCE;
            r_cfg.dot_limit_ms   <= mkd_pkg::DEF_DOT_LIM;
            r_cfg.dash_limit_ms  <= mkd_pkg::DEF_DASH_LIM;
            r_cfg.letter_gap_ms  <= mkd_pkg::DEF_LETTER;
            r_cfg.word_gap_ms    <= mkd_pkg::DEF_WORD;
            r_cfg.message_gap_ms <= mkd_pkg::DEF_MESSAGE;
        end else if (i_cfg_we) begin
            unique case (mkd_pkg::t_cfg_idx'(i_cfg_index))
                mkd_pkg::CFG_DEBOUNCE: r_cfg.debounce_ms    <= i_cfg_data;
                mkd_pkg::CFG_DOT_LIM:  r_cfg.dot_limit_ms   <= i_cfg_data;
                mkd_pkg::CFG_DASH_LIM: r_cfg.dash_limit_ms  <= i_cfg_data;
                mkd_pkg::CFG_LETTER:   r_cfg.letter_gap_ms  <= i_cfg_data;
                mkd_pkg::CFG_WORD:     r_cfg.word_gap_ms    <= i_cfg_data;
                mkd_pkg::CFG_MESSAGE:  r_cfg.message_gap_ms <= i_cfg_data;
                default: ;
            endcase
        end
    end

    mkd_key_timer u_key_timer (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_accept  (accept),
        .i_item    (i_item),
        .i_cfg     (r_cfg),
        .o_s1      (s1),
        .o_ram_req (ram_req)
    );

    mkd_ram #(
        .WIDTH  (mkd_pkg::SYM_W),
        .DEPTH  (mkd_pkg::TBL_DEPTH),
        .ADDR_W (mkd_pkg::TBL_ADDR_W)
    ) u_symbol_ram (
        .i_clk   (i_clk),
        .i_we    (ram_req.we),
        .i_waddr (ram_req.waddr),
        .i_wdata (ram_req.wdata),
        .i_raddr (ram_req.raddr),
        .o_rdata (rdata)
    );

    mkd_event_gen u_event_gen (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_s1    (s1),
        .i_rdata (rdata),
        .o_push  (push)
    );

    mkd_result_fifo u_result_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_pop   (pop),
        .o_head  (o_result),
        .o_count (q_count)
    );

    a_key_gives_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (accept && (i_item.opcode == mkd_pkg::OP_KEY)) |=> (push.n != 2'd0))
        else $error("key sample transfer produced no result");

    a_table_no_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (accept && (i_item.opcode == mkd_pkg::OP_TABLE)) |=> (push.n == 2'd0))
        else $error("table write produced a result");

    a_queue_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (q_count <= CW'(mkd_pkg::RES_DEPTH)))
        else $error("result queue overflow");

    a_pop_shrinks: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (pop && (push.n == 2'd0)) |=> (q_count == $past(q_count) - CW'(1)))
        else $error("result queue count wrong after transfer");

endmodule
